// ----- rtl/graf_pkg.sv -----
// Shared types, codes and helper functions of the GPIO register access filter.
package graf_pkg;

  // Fixed field widths of the command and result beats
  localparam int DATA_W   = 32;
  localparam int WORD_W   = 10;
  localparam int PORT_W   = 7;
  localparam int PIN_W    = 3;
  localparam int BE_W     = 4;
  localparam int OFS_W    = WORD_W + 2;

  // Widest store addresses over the legal parameter range
  localparam int RA_MAX_W = 12;
  localparam int GA_MAX_W = 9;

  // Command queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // Command codes
  localparam logic [2:0] CMD_READ   = 3'd0;
  localparam logic [2:0] CMD_WRITE  = 3'd1;
  localparam logic [2:0] CMD_GRANT  = 3'd2;
  localparam logic [2:0] CMD_REVOKE = 3'd3;
  localparam logic [2:0] CMD_FILL   = 3'd4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTION_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BANK_PRESENT = 1'b1;

  // Action modes; the unused code behaves like pass
  localparam logic [1:0] MODE_PASS   = 2'd0;
  localparam logic [1:0] MODE_REPORT = 2'd1;
  localparam logic [1:0] MODE_MASK   = 2'd2;

  // Byte offsets of the unimplemented windows and size of one port's slice
  localparam logic [OFS_W-1:0] UNIMPL_LO  = 12'h700;
  localparam logic [OFS_W-1:0] UNIMPL_HI  = 12'hC00;
  localparam logic [OFS_W-1:0] UNIMPL_TOP = 12'hE00;
  localparam int               PORT_BYTES = 'h20;

  // Register kind within a port slice (byte offset bits 4:2)
  localparam logic [2:0] REG_CON    = 3'd0;
  localparam logic [2:0] REG_DAT    = 3'd1;
  localparam logic [2:0] REG_PUD    = 3'd2;
  localparam logic [2:0] REG_DRV    = 3'd3;
  localparam logic [2:0] REG_CONPDN = 3'd4;
  localparam logic [2:0] REG_PUDPDN = 3'd5;

  // Grant fill patterns
  localparam logic [7:0] FILL_ALLOW = 8'hFF;
  localparam logic [7:0] FILL_DENY  = 8'h00;

  typedef struct packed {
    logic [2:0]        cmd;
    logic              bank;
    logic [WORD_W-1:0] word_index;
    logic [BE_W-1:0]   byte_enable;
    logic [DATA_W-1:0] write_data;
    logic [PORT_W-1:0] port;
    logic [PIN_W-1:0]  pin;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] prior_value;
    logic              violation;
  } out_t;

  typedef enum logic [2:0] {
    OP_READ,
    OP_WRITE,
    OP_GRANT,
    OP_REVOKE,
    OP_FILL,
    OP_NOP
  } op_t;

  typedef enum logic [2:0] {
    KIND_ALL,
    KIND_CON,
    KIND_DAT,
    KIND_TWO,
    KIND_NONE
  } kind_t;

  // Classified command as it waits in the queue
  typedef struct packed {
    op_t                 op;
    logic                usable;
    logic                gsel_ok;
    logic [RA_MAX_W-1:0] ra;
    logic [GA_MAX_W-1:0] ga;
    kind_t               kind;
    logic [BE_W-1:0]     byte_enable;
    logic [DATA_W-1:0]   write_data;
    logic [PIN_W-1:0]    pin;
  } entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_FILL
  } back_state_t;

  // Allowed bits of a register from the granted pins of its port
  function automatic logic [DATA_W-1:0] field_mask(logic [7:0] granted, kind_t kind);
    logic [DATA_W-1:0] m;
    m = '0;
    case (kind)
      KIND_ALL: m = '1;
      KIND_CON: for (int p = 0; p < 8; p++) m[4*p +: 4] = {4{granted[p]}};
      KIND_DAT: m[7:0] = granted;
      KIND_TWO: for (int p = 0; p < 8; p++) m[2*p +: 2] = {2{granted[p]}};
      default:  m = '0;
    endcase
    return m;
  endfunction

  // Expand byte enables to a bit mask
  function automatic logic [DATA_W-1:0] byte_mask(logic [BE_W-1:0] be);
    logic [DATA_W-1:0] m;
    for (int k = 0; k < BE_W; k++) m[8*k +: 8] = {8{be[k]}};
    return m;
  endfunction

endpackage

// ----- rtl/graf_ram.sv -----
// Generic single-port RAM with registered read data.
module graf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write on enable, read the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/graf_front.sv -----
// Front end: accepts commands, classifies them and pushes them into the queue.
module graf_front #(
  parameter int BANK_WORDS     = 1024,
  parameter int PORTS_PER_BANK = 128,
  parameter int NUM_BANKS      = 2
) (
  input  logic            start,
  output logic            busy,
  input  graf_pkg::in_t   in_data,
  input  logic [1:0]      bank_present,
  input  logic            queue_full,
  input  logic            clearing,
  output logic            push,
  output graf_pkg::entry_t entry
);
  import graf_pkg::*;

  logic [OFS_W-1:0]  offset;
  logic              bank_ok;
  logic              word_ok;
  logic              unimpl;
  logic [PORT_W-1:0] gport;
  logic              gport_ok;
  kind_t             kind;
  op_t               op;

  // Hold off while the queue is full or the stores are being cleared
  assign busy = queue_full | clearing;
  assign push = start & ~busy;

  assign offset  = {in_data.word_index, 2'b00};
  assign bank_ok = ({2'b00, in_data.bank} < 3'(NUM_BANKS)) & bank_present[in_data.bank];
  assign word_ok = ({1'b0, in_data.word_index} < 11'(BANK_WORDS));
  assign unimpl  = ((offset >= UNIMPL_LO) && (offset < UNIMPL_HI)) || (offset >= UNIMPL_TOP);

  // Decode the command
  always_comb begin
    unique case (in_data.cmd)
      CMD_READ:   op = OP_READ;
      CMD_WRITE:  op = OP_WRITE;
      CMD_GRANT:  op = OP_GRANT;
      CMD_REVOKE: op = OP_REVOKE;
      CMD_FILL:   op = OP_FILL;
      default:    op = OP_NOP;
    endcase
  end

  // Classify the register kind from its offset
  always_comb begin
    if (unimpl) begin
      kind = KIND_ALL;
    end else begin
      unique case (offset[4:2]) inside
        REG_CON:                               kind = KIND_CON;
        REG_DAT:                               kind = KIND_DAT;
        REG_PUD, REG_DRV, REG_CONPDN, REG_PUDPDN: kind = KIND_TWO;
        default:                               kind = KIND_NONE;
      endcase
    end
  end

  // Writes look up the port owning the offset; grant edits name it directly
  assign gport    = (op == OP_WRITE) ? PORT_W'(offset / PORT_BYTES) : in_data.port;
  assign gport_ok = ({1'b0, gport} < 8'(PORTS_PER_BANK));

  // Build the queue entry
  always_comb begin
    entry.op          = op;
    entry.usable      = bank_ok & word_ok;
    entry.gsel_ok     = ({2'b00, in_data.bank} < 3'(NUM_BANKS)) & gport_ok;
    entry.ra          = RA_MAX_W'({2'b00, in_data.word_index})
                        + (in_data.bank ? RA_MAX_W'(BANK_WORDS) : '0);
    entry.ga          = GA_MAX_W'({2'b00, gport})
                        + (in_data.bank ? GA_MAX_W'(PORTS_PER_BANK) : '0);
    entry.kind        = kind;
    entry.byte_enable = in_data.byte_enable;
    entry.write_data  = in_data.write_data;
    entry.pin         = in_data.pin;
  end

endmodule

// ----- rtl/graf_fifo.sv -----
// Short command queue between the front end and the back end.
module graf_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  graf_pkg::entry_t push_data,
  input  logic             pop,
  output graf_pkg::entry_t head,
  output logic             full,
  output logic             empty
);
  import graf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/graf_back.sv -----
// Back end: runs queued commands against the register and grant stores.
module graf_back #(
  parameter int BANK_WORDS     = 1024,
  parameter int PORTS_PER_BANK = 128,
  parameter int NUM_BANKS      = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       action_mode,
  input  graf_pkg::entry_t head,
  input  logic             empty,
  output logic             pop,
  output logic             clearing,
  output logic             out_valid,
  output graf_pkg::out_t   out_data
);
  import graf_pkg::*;

  localparam int RDEPTH  = NUM_BANKS * BANK_WORDS;
  localparam int GDEPTH  = NUM_BANKS * PORTS_PER_BANK;
  localparam int SWEEP_N = (RDEPTH > GDEPTH) ? RDEPTH : GDEPTH;
  localparam int RA_W    = $clog2(RDEPTH);
  localparam int GA_W    = $clog2(GDEPTH);
  localparam int CNT_W   = $clog2(SWEEP_N);

  back_state_t      state_r, state_nxt;
  entry_t           op_r, op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;

  logic              reg_we;
  logic [RA_W-1:0]   reg_addr;
  logic [DATA_W-1:0] reg_wdata;
  logic [DATA_W-1:0] reg_rdata;
  logic              gnt_we;
  logic [GA_W-1:0]   gnt_addr;
  logic [7:0]        gnt_wdata;
  logic [7:0]        gnt_rdata;

  logic [7:0]        granted;
  logic [DATA_W-1:0] allow;
  logic [DATA_W-1:0] bmask;
  logic [DATA_W-1:0] merged;
  logic              hit;
  logic              report;
  logic [DATA_W-1:0] stored;
  logic [7:0]        pin_bit;

  graf_ram #(.WIDTH(DATA_W), .DEPTH(RDEPTH)) u_reg_ram (
    .clk   (clk),
    .we    (reg_we),
    .addr  (reg_addr),
    .wdata (reg_wdata),
    .rdata (reg_rdata)
  );

  graf_ram #(.WIDTH(8), .DEPTH(GDEPTH)) u_gnt_ram (
    .clk   (clk),
    .we    (gnt_we),
    .addr  (gnt_addr),
    .wdata (gnt_wdata),
    .rdata (gnt_rdata)
  );

  // Write datapath: merge by byte enables, check against allowed bits
  assign granted = op_r.gsel_ok ? gnt_rdata : 8'h00;
  assign allow   = field_mask(granted, op_r.kind);
  assign bmask   = byte_mask(op_r.byte_enable);
  assign merged  = (reg_rdata & ~bmask) | (op_r.write_data & bmask);
  assign hit     = |((merged ^ reg_rdata) & ~allow);
  assign report  = (action_mode == MODE_REPORT) || (action_mode == MODE_MASK);
  assign stored  = (hit && action_mode == MODE_MASK) ? ((merged & allow) | (reg_rdata & ~allow))
                                                     : merged;
  assign pin_bit = 8'(1) << op_r.pin;

  assign clearing  = (state_r == ST_CLEAR);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next state and store controls
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    reg_we        = 1'b0;
    reg_addr      = op_r.ra[RA_W-1:0];
    reg_wdata     = stored;
    gnt_we        = 1'b0;
    gnt_addr      = op_r.ga[GA_W-1:0];
    gnt_wdata     = gnt_rdata;

    unique case (state_r)
      // Sweep both stores to zero after reset
      ST_CLEAR: begin
        reg_addr  = cnt_r[RA_W-1:0];
        gnt_addr  = cnt_r[GA_W-1:0];
        reg_wdata = '0;
        gnt_wdata = FILL_DENY;
        reg_we    = ({1'b0, cnt_r} < (CNT_W + 1)'(RDEPTH));
        gnt_we    = ({1'b0, cnt_r} < (CNT_W + 1)'(GDEPTH));
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SWEEP_N - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end

      // Take the next command and start both store reads
      ST_IDLE: begin
        reg_addr = head.ra[RA_W-1:0];
        gnt_addr = head.ga[GA_W-1:0];
        if (!empty) begin
          pop    = 1'b1;
          op_nxt = head;
          if (head.op == OP_FILL) begin
            cnt_nxt   = '0;
            state_nxt = ST_FILL;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end

      // Read data is back: update stores and emit the result
      ST_EXEC: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '0;
        case (op_r.op)
          OP_READ: begin
            if (op_r.usable) begin
              out_data_nxt.read_data   = reg_rdata;
              out_data_nxt.prior_value = reg_rdata;
            end
          end
          OP_WRITE: begin
            if (op_r.usable) begin
              reg_we                   = 1'b1;
              out_data_nxt.read_data   = stored;
              out_data_nxt.prior_value = reg_rdata;
              out_data_nxt.violation   = hit & report;
            end
          end
          OP_GRANT: begin
            gnt_we    = op_r.gsel_ok;
            gnt_wdata = gnt_rdata | pin_bit;
          end
          OP_REVOKE: begin
            gnt_we    = op_r.gsel_ok;
            gnt_wdata = gnt_rdata & ~pin_bit;
          end
          default: begin
          end
        endcase
        state_nxt = ST_IDLE;
      end

      // Sweep the fill pattern over every grant entry
      ST_FILL: begin
        gnt_we    = 1'b1;
        gnt_addr  = cnt_r[GA_W-1:0];
        gnt_wdata = op_r.write_data[0] ? FILL_ALLOW : FILL_DENY;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(GDEPTH - 1)) begin
          cnt_nxt       = '0;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the command and result payload
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- rtl/gpio_register_access_filter.sv -----
// Top level of the GPIO register access filter: config registers, front, queue and back.
//
//   Channel  Ports                               Handshake
//   command  start, busy, in_data                beat taken when start & !busy
//   result   out_valid, out_data                 one-cycle strobe, no backpressure
//   config   cfg_valid, cfg_ready, cfg_index,    write taken when cfg_valid & cfg_ready
//            cfg_data
//
// Read, write, grant and revoke run in the back end as a store read, then an
// update, set by the single port of each store. With an empty queue and an idle
// back end a taken command passes the queue, the idle state and the execute state
// before the registered result strobe rises. Fill sweeps the grant store, one
// grant entry per cycle, before its result strobe.
// After reset, busy stays high while both stores are cleared.
// Busy is high while the two-entry queue is full or the clear sweep runs.
module gpio_register_access_filter #(
  parameter int BANK_WORDS     = 1024,
  parameter int PORTS_PER_BANK = 128,
  parameter int NUM_BANKS      = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  graf_pkg::in_t                       in_data,
  output logic                                out_valid,
  output graf_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [graf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [graf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import graf_pkg::*;

  logic [1:0] mode_r;
  logic [1:0] bank_present_r;
  logic       push;
  logic       pop;
  logic       queue_full;
  logic       queue_empty;
  logic       clearing;
  entry_t     entry;
  entry_t     head;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_PASS;
      bank_present_r <= 2'b11;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ACTION_MODE:  mode_r         <= cfg_data;
        CFG_BANK_PRESENT: bank_present_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  graf_front #(
    .BANK_WORDS     (BANK_WORDS),
    .PORTS_PER_BANK (PORTS_PER_BANK),
    .NUM_BANKS      (NUM_BANKS)
  ) u_front (
    .start        (start),
    .busy         (busy),
    .in_data      (in_data),
    .bank_present (bank_present_r),
    .queue_full   (queue_full),
    .clearing     (clearing),
    .push         (push),
    .entry        (entry)
  );

  graf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (entry),
    .pop       (pop),
    .head      (head),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  graf_back #(
    .BANK_WORDS     (BANK_WORDS),
    .PORTS_PER_BANK (PORTS_PER_BANK),
    .NUM_BANKS      (NUM_BANKS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .action_mode (mode_r),
    .head        (head),
    .empty       (queue_empty),
    .pop         (pop),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule

// ----- rtl/graf_checker.sv -----
// Port-level checks of the GPIO register access filter and their bind.
module graf_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid
);

  // Each command yields at most one result beat, never back to back
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe high two cycles in a row");

  // Reset drops the result strobe and blocks commands
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && busy))
    else $error("strobe or ready seen right after reset");

  // The clear sweep holds commands off as reset is released
  a_clear_busy: assert property (@(posedge clk)
    $rose(rst_n) |-> busy)
    else $error("commands taken before stores were cleared");

endmodule

bind gpio_register_access_filter graf_checker u_graf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_valid (out_valid)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for the GPIO register access filter: each result beat checked against a prediction.
module testbench;
  import graf_pkg::*;

  // Codes that the package leaves unnamed
  localparam logic [2:0] CMD_SPARE   = 3'd5;
  localparam logic [2:0] CMD_LAST    = 3'd7;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Word ranges of the unimplemented windows
  localparam int LO_WIN_FIRST  = UNIMPL_LO / 4;
  localparam int LO_WIN_LAST   = UNIMPL_HI / 4 - 1;
  localparam int TOP_WIN_FIRST = UNIMPL_TOP / 4;
  localparam int WORD_LAST     = 1023;
  localparam int PORT_LAST     = 127;

  localparam int PHASE_ITEMS = 190;
  localparam int DRAIN_CYCLES = 300;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_t                   in_data;
  logic                  out_valid;
  out_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow copy of the block's state and configuration
  logic [DATA_W-1:0] reg_image [0:2047];
  logic [7:0]        grant_image [0:255];
  logic [1:0]        cur_mode;
  logic [1:0]        cur_present;

  out_t expected_beats [$];
  out_t want;
  int   fail_count = 0;
  int   burst_left = 0;

  gpio_register_access_filter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Update the shadow state for one accepted command and return its result beat
  function automatic out_t apply_access(input in_t it);
    out_t             res;
    logic [OFS_W-1:0] ofs;
    logic [DATA_W-1:0] old_word, merged, allowed, bmask;
    logic [7:0]       granted;
    logic [10:0]      ridx;
    logic [7:0]       gidx;
    res = '0;
    ridx = {it.bank, it.word_index};
    gidx = {it.bank, it.port};
    case (it.cmd)
      CMD_READ: begin
        if (cur_present[it.bank]) begin
          res.read_data = reg_image[ridx];
          res.prior_value = reg_image[ridx];
        end
      end
      CMD_WRITE: begin
        if (cur_present[it.bank]) begin
          old_word = reg_image[ridx];
          bmask = '0;
          for (int k = 0; k < BE_W; k++) begin
            if (it.byte_enable[k]) bmask[8*k +: 8] = 8'hFF;
          end
          merged = (old_word & ~bmask) | (it.write_data & bmask);
          // build the allowed bits from the register kind and the port's grants
          ofs = {it.word_index, 2'b00};
          if ((ofs >= UNIMPL_LO && ofs < UNIMPL_HI) || ofs >= UNIMPL_TOP) begin
            allowed = '1;
          end else begin
            allowed = '0;
            granted = grant_image[{it.bank, it.word_index[9:3]}];
            for (int p = 0; p < 8; p++) begin
              if (granted[p]) begin
                case (it.word_index[2:0])
                  REG_CON: allowed[4*p +: 4] = 4'hF;
                  REG_DAT: allowed[p] = 1'b1;
                  REG_PUD, REG_DRV, REG_CONPDN, REG_PUDPDN: allowed[2*p +: 2] = 2'b11;
                  default: ;
                endcase
              end
            end
          end
          if (((merged ^ old_word) & ~allowed) != '0) begin
            if (cur_mode == MODE_MASK) begin
              merged = (merged & allowed) | (old_word & ~allowed);
              res.violation = 1'b1;
            end else if (cur_mode == MODE_REPORT) begin
              res.violation = 1'b1;
            end
          end
          reg_image[ridx] = merged;
          res.read_data = merged;
          res.prior_value = old_word;
        end
      end
      CMD_GRANT: grant_image[gidx][it.pin] = 1'b1;
      CMD_REVOKE: grant_image[gidx][it.pin] = 1'b0;
      CMD_FILL: begin
        foreach (grant_image[g]) grant_image[g] = it.write_data[0] ? FILL_ALLOW : FILL_DENY;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic in_t make_cmd(input logic [2:0] cmd, input int bank,
                                   input int word, input logic [BE_W-1:0] be,
                                   input logic [DATA_W-1:0] data, input int port,
                                   input int pin);
    in_t it;
    it.cmd = cmd;
    it.bank = 1'(bank);
    it.word_index = WORD_W'(word);
    it.byte_enable = be;
    it.write_data = data;
    it.port = PORT_W'(port);
    it.pin = PIN_W'(pin);
    return it;
  endfunction

  // Mostly traffic on the first ports and their grants, the rest spread everywhere
  function automatic in_t random_command();
    in_t it;
    int  pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) it.cmd = CMD_READ;
    else if (pick < 70) it.cmd = CMD_WRITE;
    else if (pick < 82) it.cmd = CMD_GRANT;
    else if (pick < 92) it.cmd = CMD_REVOKE;
    else if (pick < 94) it.cmd = CMD_FILL;
    else it.cmd = 3'($urandom_range(CMD_SPARE, CMD_LAST));
    it.bank = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 70) it.word_index = WORD_W'($urandom_range(0, 3) * 8 + $urandom_range(0, 7));
    else if (pick < 78) it.word_index = WORD_W'($urandom_range(LO_WIN_FIRST, LO_WIN_LAST));
    else if (pick < 85) it.word_index = WORD_W'($urandom_range(TOP_WIN_FIRST, WORD_LAST));
    else it.word_index = WORD_W'($urandom_range(0, WORD_LAST));
    it.byte_enable = BE_W'($urandom_range(0, 15));
    pick = $urandom_range(0, 9);
    if (pick == 0) it.write_data = '0;
    else if (pick == 1) it.write_data = '1;
    else it.write_data = $urandom;
    if ($urandom_range(0, 3) != 0) it.port = PORT_W'($urandom_range(0, 3));
    else it.port = PORT_W'($urandom_range(0, PORT_LAST));
    it.pin = PIN_W'($urandom_range(0, 7));
    return it;
  endfunction

  // Hold start until the block takes the beat, then record its prediction
  task automatic send_command(input in_t item);
    start <= 1'b1;
    in_data <= item;
    do @(negedge clk); while (busy !== 1'b0);
    @(posedge clk);
    expected_beats.push_back(apply_access(item));
  endtask

  // Drop start between bursts for a random gap
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 12);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it
  task automatic write_config(input logic [CFG_IDX_W-1:0] index,
                              input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(negedge clk); while (cfg_ready !== 1'b1);
    @(posedge clk);
    if (index == CFG_ACTION_MODE) cur_mode = value;
    else if (index == CFG_BANK_PRESENT) cur_present = value;
  endtask

  task automatic set_phase(input logic [1:0] mode, input logic [1:0] present);
    wait_drained();
    write_config(CFG_ACTION_MODE, mode);
    write_config(CFG_BANK_PRESENT, present);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_grant_masking();
    set_phase(MODE_MASK, 2'b11);
    send_command(make_cmd(CMD_READ, 0, 0, 4'hF, '1, 0, 0));
    send_command(make_cmd(CMD_WRITE, 0, 0, 4'hF, '1, 0, 0));
    send_command(make_cmd(CMD_GRANT, 0, 0, 4'h0, '0, 0, 7));
    send_command(make_cmd(CMD_WRITE, 0, 0, 4'hF, '1, 0, 0));
    send_command(make_cmd(CMD_WRITE, 0, 1, 4'h1, 32'h0000_00FF, 0, 0));
    send_command(make_cmd(CMD_WRITE, 0, 2, 4'h0, '1, 0, 0));
    send_command(make_cmd(CMD_WRITE, 0, 6, 4'hF, 32'h1, 0, 0));
    send_command(make_cmd(CMD_REVOKE, 0, 0, 4'h0, '0, 0, 7));
    send_command(make_cmd(CMD_WRITE, 0, 0, 4'hF, '0, 0, 0));
  endtask

  task automatic test_window_edges();
    send_command(make_cmd(CMD_WRITE, 0, LO_WIN_FIRST, 4'hF, '1, 0, 0));
    send_command(make_cmd(CMD_WRITE, 0, LO_WIN_LAST, 4'hF, '1, 0, 0));
    send_command(make_cmd(CMD_WRITE, 0, LO_WIN_LAST + 1, 4'hF, '1, 0, 0));
    send_command(make_cmd(CMD_WRITE, 0, WORD_LAST, 4'hF, '1, 0, 0));
  endtask

  task automatic test_fill_and_unused();
    send_command(make_cmd(CMD_SPARE, 1, WORD_LAST, 4'hF, '1, PORT_LAST, 7));
    send_command(make_cmd(CMD_LAST, 0, 0, 4'hF, '1, 0, 0));
    send_command(make_cmd(CMD_FILL, 0, 0, 4'h0, 32'h1, 0, 0));
    send_command(make_cmd(CMD_WRITE, 1, 3, 4'hF, '1, 0, 0));
    send_command(make_cmd(CMD_WRITE, 1, 4, 4'h3, '1, 0, 0));
    send_command(make_cmd(CMD_WRITE, 1, 5, 4'hC, '1, 0, 0));
    send_command(make_cmd(CMD_FILL, 0, 0, 4'h0, 32'hFFFF_FFFE, 0, 0));
    send_command(make_cmd(CMD_GRANT, 1, 0, 4'h0, '0, PORT_LAST, 0));
    send_command(make_cmd(CMD_REVOKE, 1, 0, 4'h0, '0, PORT_LAST, 7));
  endtask

  task automatic test_absent_bank();
    set_phase(MODE_REPORT, 2'b01);
    send_command(make_cmd(CMD_WRITE, 1, 0, 4'hF, '1, 0, 0));
    send_command(make_cmd(CMD_READ, 1, 3, 4'h0, '0, 0, 0));
    set_phase(MODE_PASS, 2'b00);
    send_command(make_cmd(CMD_READ, 0, 0, 4'h0, '0, 0, 0));
    set_phase(MODE_UNUSED, 2'b11);
    send_command(make_cmd(CMD_WRITE, 0, 0, 4'hF, '1, 0, 0));
  endtask

  task automatic test_random_traffic();
    logic [1:0] modes [8];
    logic [1:0] presents [8];
    modes = '{MODE_PASS, MODE_REPORT, MODE_MASK, MODE_UNUSED,
              MODE_MASK, MODE_REPORT, MODE_MASK, MODE_MASK};
    presents = '{2'b11, 2'b11, 2'b11, 2'b11, 2'b10, 2'b01, 2'b00, 2'b11};
    for (int ph = 0; ph < 8; ph++) begin
      set_phase(modes[ph], presents[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_command(random_command());
        pace();
      end
    end
  endtask

  // Compare each result beat with the oldest prediction
  always @(negedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing pending: read_data %h prior_value %h violation %b",
               out_data.read_data, out_data.prior_value, out_data.violation);
        fail_count++;
      end else begin
        want = expected_beats.pop_front();
        if (out_data.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, out_data.read_data);
          fail_count++;
        end
        if (out_data.prior_value !== want.prior_value) begin
          $error("prior_value: expected %h, got %h", want.prior_value, out_data.prior_value);
          fail_count++;
        end
        if (out_data.violation !== want.violation) begin
          $error("violation: expected %b, got %b", want.violation, out_data.violation);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    foreach (reg_image[i]) reg_image[i] = '0;
    foreach (grant_image[g]) grant_image[g] = '0;
    cur_mode = MODE_PASS;
    cur_present = 2'b11;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_grant_masking();
    test_window_edges();
    test_fill_and_unused();
    test_absent_bank();
    test_random_traffic();
    // let the last fill sweep and any stray beat show up
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_beats.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
